/* rtl/tldw_pkg.sv */
`timescale 1ns / 1ps

package tldw_pkg;

    // Display command bytes
    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_CTRL    = 8'h80;
    localparam logic [3:0] BRIGHT_MASK = 4'hF;

    // Default digit store depth
    localparam int unsigned MAX_DIGITS_DEF = 6;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 1'b1;
    localparam int unsigned CFG_DATA_W = 4;

    // Payload widths
    localparam int unsigned DIGIT_BITS_W = 48;
    localparam int unsigned COUNT_W      = 3;

    // Group codes
    localparam logic [1:0] GRP_DATA = 2'd0;
    localparam logic [1:0] GRP_ADDR = 2'd1;
    localparam logic [1:0] GRP_CTRL = 2'd2;

    // Open-drain drive levels, 1 pulls the line low
    typedef struct packed {
        logic dio_low;
        logic clk_low;
    } t_lines;

    function automatic logic [7:0] group_command(input logic [1:0] grp,
                                                 input logic [3:0] bright);
        logic [7:0] cmd;
        case (grp)
            GRP_DATA: cmd = CMD_DATA;
            GRP_ADDR: cmd = CMD_ADDR;
            default:  cmd = CMD_CTRL | {4'h0, bright & BRIGHT_MASK};
        endcase
        return cmd;
    endfunction

endpackage

/* rtl/two_wire_led_display_writer.sv */
`timescale 1ns / 1ps

// Channel   | Handshake                    | Payload
// ----------+------------------------------+-------------------------------------------
// tick in   | i_in_valid / o_in_ready      | i_load, i_digit_bits, i_dio_in
// line out  | o_out_valid / i_out_ready    | o_clk_low, o_dio_low, o_busy_res,
//           |                              | o_ack_valid, o_ack_missing
// config    | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One tick word is taken per clock cycle while o_in_ready is high; its line word sits in
// the output register in the next cycle. The sequencer state and the output register
// advance on the same edge, so the only latency is that single result register.
// The output register stalls the input side only while it holds a word that is not
// being taken in the same cycle.
// Reset (synchronous, active low) releases both lines, clears the sequencer and the
// digit store, and restores digit_count to 6 and brightness to 15.

module two_wire_led_display_writer
    import tldw_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // tick words
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_load,
    input  logic [DIGIT_BITS_W-1:0] i_digit_bits,
    input  logic                    i_dio_in,
    // line words
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_clk_low,
    output logic                    o_dio_low,
    output logic                    o_busy_res,
    output logic                    o_ack_valid,
    output logic                    o_ack_missing,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

    // Sequencer phases
    localparam logic [2:0] S_BITS       = 3'd0;
    localparam logic [2:0] S_ACK_LOW    = 3'd1;
    localparam logic [2:0] S_ACK_SAMPLE = 3'd2;
    localparam logic [2:0] S_ACK_END    = 3'd3;
    localparam logic [2:0] S_START      = 3'd4;
    localparam logic [2:0] S_STOP0      = 3'd5;
    localparam logic [2:0] S_STOP1      = 3'd6;
    localparam logic [2:0] S_STOP2      = 3'd7;

    // Configuration
    logic [COUNT_W-1:0] r_digit_count;
    logic [3:0]         r_brightness;

    // Sequencer state
    logic [7:0]         r_store [MAX_DIGITS];
    logic               r_pending, n_pending;
    logic               r_active,  n_active;
    logic [1:0]         r_group,   n_group;
    logic [2:0]         r_state,   n_state;
    logic [1:0]         r_sub,     n_sub;      // tick within a bit
    logic [2:0]         r_bit,     n_bit;      // bit of the byte, LSB first
    logic [COUNT_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]         r_shift,   n_shift;
    t_lines             r_lines,   n_lines;

    // Output register
    logic               r_out_valid;
    t_lines             r_res_lines;
    logic               r_res_busy, r_res_ackv, r_res_ackm;
    logic               n_busy, n_ackv, n_ackm;

    logic               in_acc;
    logic               start_now;
    logic               go;
    logic [2:0]         cur_state;
    logic [1:0]         cur_group;
    logic [COUNT_W-1:0] eff_count;
    logic [IDX_W-1:0]   rd_idx;
    logic [7:0]         rd_byte;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // Clamp the digit count to the store depth
    assign eff_count = (r_digit_count > MAX_CNT) ? MAX_CNT : r_digit_count;

    // Read the next digit; a load on this tick overrides the stored contents
    assign rd_idx  = r_byte_idx[IDX_W-1:0];
    assign rd_byte = i_load ? i_digit_bits[{rd_idx, 3'b000} +: 8] : r_store[rd_idx];

    // A load or a pending refresh that finds the writer idle starts on this tick
    assign start_now = !r_active && (r_pending || i_load);
    assign go        = r_active || start_now;
    assign cur_state = start_now ? S_START : r_state;
    assign cur_group = start_now ? GRP_DATA : r_group;

    always_comb begin
        n_pending  = (r_pending || i_load) && !start_now;
        n_active   = go;
        n_group    = cur_group;
        n_state    = cur_state;
        n_sub      = r_sub;
        n_bit      = r_bit;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_lines    = r_lines;
        n_busy     = 1'b0;
        n_ackv     = 1'b0;
        n_ackm     = 1'b0;
        if (go) begin
            n_busy = 1'b1;
            unique case (cur_state)
                S_BITS: begin
                    if (r_sub == 2'd0) begin
                        n_lines.clk_low = 1'b1;
                        n_sub           = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_lines.dio_low = !r_shift[r_bit];
                        n_sub           = 2'd2;
                    end else begin
                        n_lines.clk_low = 1'b0;
                        n_sub           = 2'd0;
                        n_bit           = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            n_state = S_ACK_LOW;
                        end
                    end
                end
                S_ACK_LOW: begin
                    n_lines.clk_low = 1'b1;
                    n_lines.dio_low = 1'b0;
                    n_state         = S_ACK_SAMPLE;
                end
                S_ACK_SAMPLE: begin
                    n_lines.clk_low = 1'b0;
                    n_lines.dio_low = !i_dio_in;
                    n_ackv          = 1'b1;
                    n_ackm          = i_dio_in;
                    n_state         = S_ACK_END;
                end
                S_ACK_END: begin
                    n_lines.clk_low = 1'b1;
                    if (cur_group == GRP_ADDR && r_byte_idx < eff_count) begin
                        n_shift    = rd_byte;
                        n_byte_idx = r_byte_idx + COUNT_W'(1);
                        n_bit      = 3'd0;
                        n_sub      = 2'd0;
                        n_state    = S_BITS;
                    end else begin
                        n_state = S_STOP0;
                    end
                end
                S_START: begin
                    n_lines.clk_low = 1'b0;
                    n_lines.dio_low = 1'b1;
                    n_byte_idx      = '0;
                    n_shift         = group_command(cur_group, r_brightness);
                    n_bit           = 3'd0;
                    n_sub           = 2'd0;
                    n_state         = S_BITS;
                end
                S_STOP0: begin
                    n_lines.dio_low = 1'b1;
                    n_state         = S_STOP1;
                end
                S_STOP1: begin
                    n_lines.clk_low = 1'b0;
                    n_state         = S_STOP2;
                end
                S_STOP2: begin
                    n_lines.clk_low = 1'b0;
                    n_lines.dio_low = 1'b0;
                    if (cur_group >= GRP_CTRL) begin
                        n_active = 1'b0;
                        n_group  = GRP_DATA;
                    end else begin
                        n_group  = cur_group + 2'd1;
                        n_state  = S_START;
                    end
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= COUNT_W'(6);
            r_brightness  <= 4'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[COUNT_W-1:0];
                REG_BRIGHTNESS:  r_brightness  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Digit store: overwrite on every load, latest load wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= 8'h00;
            end
        end else if (in_acc && i_load) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_store[i] <= i_digit_bits[8*i +: 8];
            end
        end
    end

    // Sequencer state: advance one phase per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_active   <= 1'b0;
            r_group    <= GRP_DATA;
            r_state    <= S_START;
            r_sub      <= 2'd0;
            r_bit      <= 3'd0;
            r_byte_idx <= '0;
            r_shift    <= 8'h00;
            r_lines    <= '0;
        end else if (in_acc) begin
            r_pending  <= n_pending;
            r_active   <= n_active;
            r_group    <= n_group;
            r_state    <= n_state;
            r_sub      <= n_sub;
            r_bit      <= n_bit;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
            r_lines    <= n_lines;
        end
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res_lines <= n_lines;
            r_res_busy  <= n_busy;
            r_res_ackv  <= n_ackv;
            r_res_ackm  <= n_ackm;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_clk_low     = r_res_lines.clk_low;
    assign o_dio_low     = r_res_lines.dio_low;
    assign o_busy_res    = r_res_busy;
    assign o_ack_valid   = r_res_ackv;
    assign o_ack_missing = r_res_ackm;

    // Both lines are released whenever no refresh is running
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_lines == '0))
        else $error("lines driven while idle");

    // Digit index never runs past the store
    a_byte_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= MAX_CNT)
        else $error("digit index beyond store depth");

    // An acknowledge report only comes from a running refresh
    a_ack_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_valid) |-> o_busy_res)
        else $error("acknowledge outside a refresh");

    // A missing acknowledge is only flagged on the sample tick
    a_ack_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_missing) |-> o_ack_valid)
        else $error("ack_missing without ack_valid");

    // A refresh left pending by the last group starts on the next accepted tick
    a_pending_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_pending && !r_active) |=> r_active)
        else $error("pending refresh not started");

endmodule

/* bench/two_wire_led_display_writer_tb.sv */
`timescale 1ns / 1ps

module two_wire_led_display_writer_tb;
    import tldw_pkg::*;

    // Phase codes of the line sequencer: 0..23 are the eight data bits, three ticks each
    localparam logic [4:0] PH_ACK_LOW    = 5'd24;
    localparam logic [4:0] PH_ACK_SAMPLE = 5'd25;
    localparam logic [4:0] PH_ACK_END    = 5'd26;
    localparam logic [4:0] PH_START      = 5'd27;
    localparam logic [4:0] PH_STOP0      = 5'd28;
    localparam logic [4:0] PH_STOP1      = 5'd29;
    localparam logic [4:0] PH_STOP2      = 5'd30;

    // Modes for the data line level fed back on each tick
    localparam int DIO_ACKED   = 0;
    localparam int DIO_MISSING = 1;
    localparam int DIO_RANDOM  = 2;

    // Length of the receiver hold-off, in cycles
    localparam int HOLD_LEN = 200;

    typedef struct packed {
        logic clk_low;
        logic dio_low;
        logic busy;
        logic ack_valid;
        logic ack_missing;
    } t_line_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_load = 1'b0;
    logic [DIGIT_BITS_W-1:0] i_digit_bits = '0;
    logic                    i_dio_in = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_clk_low;
    logic                    o_dio_low;
    logic                    o_busy_res;
    logic                    o_ack_valid;
    logic                    o_ack_missing;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = REG_DIGIT_COUNT;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    two_wire_led_display_writer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_load       (i_load),
        .i_digit_bits (i_digit_bits),
        .i_dio_in     (i_dio_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_clk_low    (o_clk_low),
        .o_dio_low    (o_dio_low),
        .o_busy_res   (o_busy_res),
        .o_ack_valid  (o_ack_valid),
        .o_ack_missing(o_ack_missing),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[two_wire_led_display_writer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer model: own copy of the configuration and the line state
    // ------------------------------------------------------------------
    logic [2:0] cfg_digit_count = 3'd6;
    logic [3:0] cfg_brightness  = 4'd15;

    logic [7:0] seq_digits [0:5] = '{default: 8'h00};
    logic       seq_pending  = 1'b0;
    logic [1:0] seq_group    = GRP_DATA;
    logic [4:0] seq_phase    = 5'd0;
    logic [2:0] seq_byte     = 3'd0;
    logic [7:0] seq_shift    = 8'h00;
    logic       seq_clk_low  = 1'b0;
    logic       seq_dio_low  = 1'b0;
    logic       seq_active   = 1'b0;

    t_line_word line_words_due [$];
    int         mismatch_count = 0;

    bit tx_gaps_on    = 1'b1;
    bit rx_stalls_on  = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_cycles   = 0;

    // Advance the line sequencer by one tick and return the levels it drives
    function automatic t_line_word advance_line_sequencer(input logic ld,
                                                          input logic [47:0] bits,
                                                          input logic dio);
        t_line_word w;
        logic       c;
        logic       d;
        logic [4:0] p;
        logic [2:0] n;
        int         i;
        w = '0;
        if (ld) begin
            for (i = 0; i < 6; i++) seq_digits[i] = bits[8*i +: 8];
            seq_pending = 1'b1;
        end
        // an idle writer picks up the refresh on the very tick it is asked for
        if (!seq_active && seq_pending) begin
            seq_active  = 1'b1;
            seq_pending = 1'b0;
            seq_group   = GRP_DATA;
            seq_phase   = PH_START;
        end
        n = (cfg_digit_count > MAX_DIGITS_DEF) ? 3'(MAX_DIGITS_DEF) : cfg_digit_count;
        if (seq_active) begin
            c = seq_clk_low;
            d = seq_dio_low;
            p = seq_phase;
            w.busy = 1'b1;
            if (p < PH_ACK_LOW) begin
                // per bit: pull clock low, set data, release clock
                case (p % 3)
                    0:       c = 1'b1;
                    1:       d = ~seq_shift[p / 3];
                    default: c = 1'b0;
                endcase
                seq_phase = p + 5'd1;
            end else begin
                case (p)
                    PH_ACK_LOW: begin
                        c = 1'b1;
                        d = 1'b0;
                        seq_phase = PH_ACK_SAMPLE;
                    end
                    PH_ACK_SAMPLE: begin
                        c = 1'b0;
                        d = ~dio;
                        w.ack_valid   = 1'b1;
                        w.ack_missing = dio;
                        seq_phase = PH_ACK_END;
                    end
                    PH_ACK_END: begin
                        c = 1'b1;
                        // digit bytes follow the address command only
                        if (seq_group == GRP_ADDR && seq_byte < n) begin
                            seq_shift = seq_digits[seq_byte];
                            seq_byte  = seq_byte + 3'd1;
                            seq_phase = 5'd0;
                        end else begin
                            seq_phase = PH_STOP0;
                        end
                    end
                    PH_START: begin
                        c = 1'b0;
                        d = 1'b1;
                        seq_byte = 3'd0;
                        case (seq_group)
                            GRP_DATA: seq_shift = CMD_DATA;
                            GRP_ADDR: seq_shift = CMD_ADDR;
                            default:  seq_shift = CMD_CTRL | {4'h0, cfg_brightness & BRIGHT_MASK};
                        endcase
                        seq_phase = 5'd0;
                    end
                    PH_STOP0: begin
                        d = 1'b1;
                        seq_phase = PH_STOP1;
                    end
                    PH_STOP1: begin
                        c = 1'b0;
                        seq_phase = PH_STOP2;
                    end
                    default: begin
                        c = 1'b0;
                        d = 1'b0;
                        if (seq_group >= GRP_CTRL) begin
                            seq_active = 1'b0;
                            seq_group  = GRP_DATA;
                            seq_phase  = 5'd0;
                        end else begin
                            seq_group = seq_group + 2'd1;
                            seq_phase = PH_START;
                        end
                    end
                endcase
            end
            seq_clk_low = c;
            seq_dio_low = d;
        end
        w.clk_low = seq_clk_low;
        w.dio_low = seq_dio_low;
        return w;
    endfunction

    function automatic logic [47:0] random_digits();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic pick_dio(input int mode);
        case (mode)
            DIO_ACKED:   return 1'b0;
            DIO_MISSING: return 1'b1;
            default:     return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tick sender: hold valid and payload until the word is taken
    // ------------------------------------------------------------------
    task automatic send_tick(input logic ld, input logic [47:0] bits, input logic dio);
        if (tx_gaps_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            i_load       <= 1'($urandom_range(0, 1));
            i_digit_bits <= random_digits();
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_load       <= ld;
        i_digit_bits <= bits;
        i_dio_in     <= dio;
        do @(posedge i_clk); while (!o_in_ready);
        line_words_due.push_back(advance_line_sequencer(ld, bits, dio));
    endtask

    task automatic run_until_idle(input int dio_mode);
        while (seq_active || seq_pending) send_tick(1'b0, random_digits(), pick_dio(dio_mode));
    endtask

    // Write both registers once every line word due has come back
    task automatic set_config(input logic [3:0] count_data, input logic [3:0] bright_data);
        i_in_valid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_DIGIT_COUNT;
        i_cfg_data <= count_data;
        @(posedge i_clk);
        cfg_digit_count = count_data[2:0];
        i_cfg_idx  <= REG_BRIGHTNESS;
        i_cfg_data <= bright_data;
        @(posedge i_clk);
        cfg_brightness = bright_data;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Line word receiver and checker
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_line_word due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_words_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: line word with none due, expected nothing, got %b%b%b%b%b",
                         $time, o_clk_low, o_dio_low, o_busy_res, o_ack_valid, o_ack_missing);
            end else begin
                due = line_words_due.pop_front();
                report_field("clk_low", due.clk_low, o_clk_low);
                report_field("dio_low", due.dio_low, o_dio_low);
                report_field("busy_res", due.busy, o_busy_res);
                report_field("ack_valid", due.ack_valid, o_ack_valid);
                report_field("ack_missing", due.ack_missing, o_ack_missing);
            end
        end
        // pick up a new hold-off request and count it down here
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_cycles = HOLD_LEN;
        end
        // a requested hold-off takes priority over the random stalls
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 28) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_ticks();
        int i;
        for (i = 0; i < 6; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_RANDOM));
    endtask

    // Refresh at reset settings, all segments lit; runs on through the next two tests
    task automatic test_reset_refresh();
        int i;
        send_tick(1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
        for (i = 0; i < 40; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_ACKED));
    endtask

    // Hold the receiver off while ticks keep coming, so the input side stalls
    task automatic test_receiver_hold_off();
        int i;
        tx_gaps_on = 1'b0;
        hold_requests++;
        for (i = 0; i < 60; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_RANDOM));
        tx_gaps_on = 1'b1;
    endtask

    // Back-to-back words on both sides until the refresh ends, then one idle tick
    task automatic test_steady_stream();
        int i;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        for (i = 0; i < 60; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_RANDOM));
        run_until_idle(DIO_RANDOM);
        send_tick(1'b0, 48'h0, 1'b1);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Digit count at zero with brightness at zero, no acknowledge anywhere
    task automatic test_count_and_brightness_edges();
        set_config(4'd0, 4'd0);
        send_tick(1'b1, 48'h0000_0000_0000, 1'b1);
        run_until_idle(DIO_MISSING);
    endtask

    // New contents arrive mid-refresh: pending refresh, latest load wins.
    // The spare data bit of the count write is set, leaving one digit.
    task automatic test_load_while_busy();
        int i;
        set_config(4'd9, 4'hA);
        send_tick(1'b1, 48'hAAAA_AAAA_AAAA, 1'b0);
        for (i = 0; i < 20; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_RANDOM));
        send_tick(1'b1, 48'h5555_5555_5555, 1'b1);
        for (i = 0; i < 20; i++) send_tick(1'b0, random_digits(), pick_dio(DIO_RANDOM));
        send_tick(1'b1, 48'hC3C3_3C3C_F00F, 1'b0);
        send_tick(1'b1, 48'h1234_5678_9ABC, 1'b1);
        run_until_idle(DIO_RANDOM);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_reset_refresh();
        test_receiver_hold_off();
        test_steady_stream();
        test_count_and_brightness_edges();
        test_load_while_busy();

        // drop valid, drain what is due, then let the result register settle
        i_in_valid <= 1'b0;
        while (line_words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[two_wire_led_display_writer] OK");
        end else begin
            $display("[two_wire_led_display_writer] ERROR");
        end
        $finish;
    end

endmodule
